FILE: design/bpg_pkg.sv
// ----------------------------------------------------------------------------
// Battery percent gauge package
// Item types, fixed widths and curve constants shared by the gauge modules.
// ----------------------------------------------------------------------------
package bpg_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int LANES       = 8;
    localparam int ACC_W       = SAMPLE_W + 3;
    localparam int CENTI_W     = 14;
    localparam int VOLT_W      = 17;
    localparam int DIFF_W      = 14;
    localparam int MUL_W       = 6;
    localparam int SEG_W       = 18;
    localparam int RECIP_W     = 19;
    localparam int SLOPE_SHIFT = 24;
    localparam int AVG_SHIFT   = ACC_W + 3;
    localparam int AVG_RECIP_W = AVG_SHIFT + 1;
    localparam int NUM_W       = 25;
    localparam int DEN_W       = 14;

    // Voltage breakpoints in units of 1/17 mV (code times 28).
    localparam logic [VOLT_W-1:0] U_3V0 = 17'd51000;
    localparam logic [VOLT_W-1:0] U_3V6 = 17'd61200;
    localparam logic [VOLT_W-1:0] U_3V8 = 17'd64600;
    localparam logic [VOLT_W-1:0] U_4V2 = 17'd71400;

    localparam logic [CENTI_W-1:0] CENTI_EMPTY = 14'd0;
    localparam logic [CENTI_W-1:0] CENTI_15    = 14'd1500;
    localparam logic [CENTI_W-1:0] CENTI_70    = 14'd7000;
    localparam logic [CENTI_W-1:0] CENTI_FULL  = 14'd10000;

    // Every segment slope reduces to a multiplier over 34: 5/34, 55/34 and
    // 15/34. The division by 34 is a multiplication by the rounded-up
    // reciprocal 2^24/34, exact for numerators below 2^18.
    localparam logic [MUL_W-1:0]   SLOPE_LOW_MUL  = 6'd5;
    localparam logic [MUL_W-1:0]   SLOPE_MID_MUL  = 6'd55;
    localparam logic [MUL_W-1:0]   SLOPE_HIGH_MUL = 6'd15;
    localparam logic [RECIP_W-1:0] SLOPE_RECIP    = 19'd493448;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
    } in_item_t;

    typedef struct packed {
        logic [CENTI_W-1:0] percent_centi;
        logic [CENTI_W-1:0] instant_percent_centi;
        logic               history_full;
    } out_item_t;

    // Curve segment found for one average code. When fixed is set, base is
    // the final charge and no slope term is added.
    typedef struct packed {
        logic               fixed;
        logic [CENTI_W-1:0] base;
        logic [SEG_W-1:0]   num;
    } curve_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_AVG,
        ST_CURVE,
        ST_SEG,
        ST_RING_RD,
        ST_UPDATE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DONE
    } state_t;

endpackage

FILE: design/bpg_sample_lane.sv
// ----------------------------------------------------------------------------
// Battery percent gauge sample lane
// Captures one ADC sample of an item, or zero when the lane is not in use.
// ----------------------------------------------------------------------------
module bpg_sample_lane #(
    parameter bit LANE_ON = 1'b1
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [bpg_pkg::SAMPLE_W-1:0] sample,
    output logic [bpg_pkg::SAMPLE_W-1:0] value
);

    logic [bpg_pkg::SAMPLE_W-1:0] value_reg;
    logic [bpg_pkg::SAMPLE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (load)
        begin
            value_next = LANE_ON ? sample : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: design/bpg_curve.sv
// ----------------------------------------------------------------------------
// Battery percent gauge curve segment
// Scales an average code to voltage and picks the segment of the charge curve.
// ----------------------------------------------------------------------------
module bpg_curve (
    input  logic [bpg_pkg::SAMPLE_W-1:0] avg,
    output bpg_pkg::curve_t              seg
);

    logic [bpg_pkg::VOLT_W-1:0] volt;
    logic [bpg_pkg::VOLT_W-1:0] diff_full;
    logic [bpg_pkg::DIFF_W-1:0] diff;
    logic [bpg_pkg::MUL_W-1:0]  mul;
    logic [bpg_pkg::DIFF_W+bpg_pkg::MUL_W-1:0] prod;

    // Code times 28 as a shift by five less a shift by two.
    assign volt = {avg, 5'b0} - {3'b0, avg, 2'b0};

    always_comb
    begin
        seg       = '0;
        diff_full = '0;
        mul       = '0;
        if (volt >= bpg_pkg::U_4V2)
        begin
            seg.fixed = 1'b1;
            seg.base  = bpg_pkg::CENTI_FULL;
        end
        else if (volt >= bpg_pkg::U_3V8)
        begin
            seg.base  = bpg_pkg::CENTI_70;
            diff_full = volt - bpg_pkg::U_3V8;
            mul       = bpg_pkg::SLOPE_HIGH_MUL;
        end
        else if (volt >= bpg_pkg::U_3V6)
        begin
            seg.base  = bpg_pkg::CENTI_15;
            diff_full = volt - bpg_pkg::U_3V6;
            mul       = bpg_pkg::SLOPE_MID_MUL;
        end
        else if (volt >= bpg_pkg::U_3V0)
        begin
            seg.base  = bpg_pkg::CENTI_EMPTY;
            diff_full = volt - bpg_pkg::U_3V0;
            mul       = bpg_pkg::SLOPE_LOW_MUL;
        end
        else
        begin
            seg.fixed = 1'b1;
            seg.base  = bpg_pkg::CENTI_EMPTY;
        end
        seg.num = prod[bpg_pkg::SEG_W-1:0];
    end

    assign diff = diff_full[bpg_pkg::DIFF_W-1:0];
    assign prod = diff * mul;

endmodule

FILE: design/bpg_serial_div.sv
// ----------------------------------------------------------------------------
// Battery percent gauge serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpg_serial_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bpg_pkg::NUM_W-1:0] dividend,
    input  logic [bpg_pkg::DEN_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [bpg_pkg::NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(bpg_pkg::NUM_W + 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [bpg_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [bpg_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [bpg_pkg::DEN_W-1:0] den_reg, den_next;
    logic [bpg_pkg::DEN_W:0]   shifted;
    logic [bpg_pkg::DEN_W:0]   trial;
    logic                      take;

    assign shifted = {rem_reg, quo_reg[bpg_pkg::NUM_W-1]};
    assign take    = shifted >= {1'b0, den_reg};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(bpg_pkg::NUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[bpg_pkg::NUM_W-2:0], take};
            rem_next  = take ? trial[bpg_pkg::DEN_W-1:0] : shifted[bpg_pkg::DEN_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/battery_percent_gauge_unit.sv
// ----------------------------------------------------------------------------
// Battery percent gauge
// Averages a reading of ADC samples, maps it to charge and smooths it over a
// ring of recent readings.
// ----------------------------------------------------------------------------
// The input channel takes one item of eight raw ADC samples; only the first
// SAMPLES_PER_READING samples count. The output channel returns one item per
// input item: the smoothed charge, the charge of this reading alone and the
// history full flag.
// One item is worked on at a time. Eight sample lanes capture the samples and
// an adder merges them. The average and the curve slope come from
// multiplications by constant reciprocals, and a serial divider, one quotient
// bit per cycle, forms the rounded history mean.
// An item passes the states sum, average, curve, segment, ring read,
// update, mean start, mean wait and done at any voltage; the mean division
// takes the most time. The next item is accepted once the result is
// registered and the unit is back in idle.
// If the receiver stalls, the result waits in the output register and the
// next item is still accepted and worked on; it then holds before its result
// would overwrite the waiting one.
// Reset clears the history pointer, the full flag and the running sum; the
// ring entries read before they have been written are not used.
// ----------------------------------------------------------------------------
module battery_percent_gauge_unit #(
    parameter int HISTORY_DEPTH       = 16,
    parameter int SAMPLES_PER_READING = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpg_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output bpg_pkg::out_item_t  out_item
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = $clog2(HISTORY_DEPTH * 10000 + 1);
    localparam logic [bpg_pkg::AVG_RECIP_W-1:0] AVG_RECIP = bpg_pkg::AVG_RECIP_W'(
        (2 ** bpg_pkg::AVG_SHIFT + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

    bpg_pkg::state_t state_reg, state_next;

    logic [bpg_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [bpg_pkg::SAMPLE_W-1:0] avg_reg, avg_next;
    bpg_pkg::curve_t              curve_reg, curve_next;
    logic [bpg_pkg::CENTI_W-1:0]  inst_reg, inst_next;
    logic [bpg_pkg::CENTI_W-1:0]  mean_reg, mean_next;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic                         full_reg, full_next;
    logic                         out_valid_reg, out_valid_next;
    bpg_pkg::out_item_t           out_item_reg, out_item_next;
    logic [bpg_pkg::CENTI_W-1:0]  ring_rd_reg;

    logic [bpg_pkg::CENTI_W-1:0]  ring_mem [HISTORY_DEPTH];

    logic [bpg_pkg::SAMPLE_W-1:0] samples   [bpg_pkg::LANES];
    logic [bpg_pkg::SAMPLE_W-1:0] lane_val  [bpg_pkg::LANES];
    logic [bpg_pkg::ACC_W-1:0]    lane_sum;
    logic                         lane_load;
    bpg_pkg::curve_t              curve_out;
    logic [CNT_W-1:0]             count;
    logic                         ring_re;
    logic                         ring_we;

    logic [bpg_pkg::ACC_W+bpg_pkg::AVG_RECIP_W-1:0] avg_prod;
    logic [bpg_pkg::SEG_W+bpg_pkg::RECIP_W-1:0]     seg_prod;

    logic                         div_start;
    logic [bpg_pkg::NUM_W-1:0]    div_num;
    logic [bpg_pkg::DEN_W-1:0]    div_den;
    logic                         div_busy;
    logic                         div_done;
    logic [bpg_pkg::NUM_W-1:0]    div_quo;

    assign samples[0] = in_item.sample_0;
    assign samples[1] = in_item.sample_1;
    assign samples[2] = in_item.sample_2;
    assign samples[3] = in_item.sample_3;
    assign samples[4] = in_item.sample_4;
    assign samples[5] = in_item.sample_5;
    assign samples[6] = in_item.sample_6;
    assign samples[7] = in_item.sample_7;

    assign in_ready  = (state_reg == bpg_pkg::ST_IDLE);
    assign lane_load = in_valid && in_ready;

    for (genvar i = 0; i < bpg_pkg::LANES; i++)
    begin : g_lane
        bpg_sample_lane #(
            .LANE_ON (i < SAMPLES_PER_READING)
        ) u_lane (
            .clk    (clk),
            .load   (lane_load),
            .sample (samples[i]),
            .value  (lane_val[i])
        );
    end

    always_comb
    begin
        lane_sum = '0;
        for (int i = 0; i < bpg_pkg::LANES; i++)
        begin
            lane_sum = lane_sum + bpg_pkg::ACC_W'(lane_val[i]);
        end
    end

    bpg_curve u_curve (
        .avg (avg_reg),
        .seg (curve_out)
    );

    bpg_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign avg_prod = acc_reg * AVG_RECIP;
    assign seg_prod = curve_reg.num * bpg_pkg::SLOPE_RECIP;

    assign count = full_reg ? CNT_W'(HISTORY_DEPTH) : CNT_W'(wp_reg);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        avg_next       = avg_reg;
        curve_next     = curve_reg;
        inst_next      = inst_reg;
        mean_next      = mean_reg;
        sum_next       = sum_reg;
        wp_next        = wp_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        ring_re        = 1'b0;
        ring_we        = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bpg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bpg_pkg::ST_SUM;
                end
            end
            bpg_pkg::ST_SUM:
            begin
                acc_next   = lane_sum;
                state_next = bpg_pkg::ST_AVG;
            end
            bpg_pkg::ST_AVG:
            begin
                avg_next   = avg_prod[bpg_pkg::AVG_SHIFT+bpg_pkg::SAMPLE_W-1:
                                      bpg_pkg::AVG_SHIFT];
                state_next = bpg_pkg::ST_CURVE;
            end
            bpg_pkg::ST_CURVE:
            begin
                curve_next = curve_out;
                state_next = bpg_pkg::ST_SEG;
            end
            bpg_pkg::ST_SEG:
            begin
                if (curve_reg.fixed)
                begin
                    inst_next = curve_reg.base;
                end
                else
                begin
                    inst_next = curve_reg.base + bpg_pkg::CENTI_W'(
                        seg_prod[bpg_pkg::SEG_W+bpg_pkg::RECIP_W-1:bpg_pkg::SLOPE_SHIFT]);
                end
                state_next = bpg_pkg::ST_RING_RD;
            end
            bpg_pkg::ST_RING_RD:
            begin
                ring_re    = 1'b1;
                state_next = bpg_pkg::ST_UPDATE;
            end
            bpg_pkg::ST_UPDATE:
            begin
                ring_we  = 1'b1;
                sum_next = sum_reg - (full_reg ? SUM_W'(ring_rd_reg) : SUM_W'(0))
                           + SUM_W'(inst_reg);
                if (wp_reg == PTR_W'(HISTORY_DEPTH - 1))
                begin
                    wp_next   = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    wp_next = wp_reg + PTR_W'(1);
                end
                state_next = bpg_pkg::ST_MEAN_GO;
            end
            bpg_pkg::ST_MEAN_GO:
            begin
                div_start  = 1'b1;
                div_num    = bpg_pkg::NUM_W'({sum_reg, 1'b0}) + bpg_pkg::NUM_W'(count);
                div_den    = bpg_pkg::DEN_W'({count, 1'b0});
                state_next = bpg_pkg::ST_MEAN_WAIT;
            end
            bpg_pkg::ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_next  = div_quo[bpg_pkg::CENTI_W-1:0];
                    state_next = bpg_pkg::ST_DONE;
                end
            end
            bpg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                      = 1'b1;
                    out_item_next.percent_centi         = mean_reg;
                    out_item_next.instant_percent_centi = inst_reg;
                    out_item_next.history_full          = full_reg;
                    state_next                          = bpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpg_pkg::ST_IDLE;
            sum_reg       <= '0;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            wp_reg        <= wp_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        avg_reg      <= avg_next;
        curve_reg    <= curve_next;
        inst_reg     <= inst_next;
        mean_reg     <= mean_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= inst_reg;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[wp_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sum_reg) <= int'(count) * 10000)
        else $error("running sum exceeds the charge of the filled entries");

    a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !div_busy)
        else $error("item accepted while the divider is busy");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == bpg_pkg::ST_MEAN_WAIT))
        else $error("divider finished outside the wait state");

    a_inst_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpg_pkg::ST_UPDATE) |-> (inst_reg <= bpg_pkg::CENTI_FULL))
        else $error("instant charge out of range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bpg_pkg::ST_DONE))
        else $error("result presented outside the done state");
`endif

endmodule
